// ===== rtl/sff_pkg.sv =====
// ----------------------------------------------------------------------------
// sff_pkg: shared types and constants for the spectral flux feature block
// Command and status bundles between controller and datapath, fixed-point
// constants and elaboration-time helpers.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [29:0] DB_OCT_Q28  = 30'd808071242;
  localparam logic [31:0] FLOOR_DB    = 32'hFF380000;  // -200.0 in Q16.16
  localparam logic [31:0] SAT_Q16     = 32'h7FFFFFFF;
  localparam logic [3:0]  NO_CLASS    = 4'd12;
  localparam logic [3:0]  KIND_FLUX   = 4'd0;
  localparam logic [3:0]  KIND_LOW    = 4'd1;
  localparam logic [3:0]  KIND_RMS    = 4'd2;
  localparam logic [3:0]  KIND_VOCAL  = 4'd3;
  localparam logic [3:0]  KIND_LAST   = 4'd15;
  localparam logic [1:0]  REG_LOW_LAST   = 2'd0;
  localparam logic [1:0]  REG_VOC_FIRST  = 2'd1;
  localparam logic [1:0]  REG_VOC_LAST   = 2'd2;

  typedef struct packed {
    logic accept;     // latch magnitude, read previous log and class
    logic log_start;  // start log2 unit
    logic log_mean;   // log2 operand is the mean power
    logic lg_mul;     // log2 -> natural log product
    logic lg_fin;     // round log1p
    logic upd;        // accumulate bin, write back log
    logic div_start;
    logic div_voc;    // divider works on vocal ratio
    logic mean_zero;  // silent frame: load floor dB
    logic db_mul;
    logic db_fin;
    logic shift;      // scale total/vocal down one bit
    logic vr_fin;     // store vocal ratio quotient
    logic vr_clr;     // vocal ratio zero
    logic emit;       // load next output word
    logic clear;      // end-of-frame clear
  } sff_cmd_t;

  typedef struct packed {
    logic log_done;
    logic div_done;
    logic last_bin;
    logic mean_zero;
    logic tot_big;
    logic tot_zero;
    logic out_free;
    logic kind_last;
  } sff_stat_t;

  // Elaboration-time log2, Q6.20, fraction by repeated squaring
  function automatic logic [25:0] log2_q20_f(logic [63:0] x);
    logic [63:0] t;
    logic [63:0] y;
    logic [5:0]  p;
    logic [19:0] fr;
    t  = x;
    p  = '0;
    fr = '0;
    if (x == 64'd0) return 26'd0;
    while (t > 64'd1) begin
      t = t >> 1;
      p = p + 6'd1;
    end
    y = (p >= 6'd31) ? (x >> (p - 6'd31)) : (x << (6'd31 - p));
    for (int i = 0; i < 20; i++) begin
      y = (y * y) >> 31;
      fr = {fr[18:0], y[32]};
      if (y[32]) y = y >> 1;
    end
    return {p, fr};
  endfunction

  function automatic logic [31:0] sat_q16(logic [63:0] v);
    return (v > {32'd0, SAT_Q16}) ? SAT_Q16 : v[31:0];
  endfunction

endpackage

// ===== rtl/sff_log2.sv =====
// ----------------------------------------------------------------------------
// sff_log2: iterative log2 unit
// Normalises the operand (byte then bit steps), then takes 20 fraction bits
// by squaring the mantissa, one bit per cycle. Operand must be non-zero.
// ----------------------------------------------------------------------------
module sff_log2 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [25:0] result
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQ   = 2'd2;

  logic [1:0]  st_r;
  logic [63:0] x_r;
  logic [5:0]  p_r;
  logic [31:0] y_r;
  logic [18:0] frac_r;
  logic [4:0]  cnt_r;
  logic        done_r;
  logic [25:0] res_r;
  logic [63:0] sq;
  logic [32:0] t;

  assign sq = {32'd0, y_r} * {32'd0, y_r};
  assign t  = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        L_IDLE: begin
          if (start) begin
            x_r  <= x;
            p_r  <= 6'd63;
            st_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (x_r[63:56] == 8'd0) begin
            x_r <= {x_r[55:0], 8'd0};
            p_r <= p_r - 6'd8;
          end else if (!x_r[63]) begin
            x_r <= {x_r[62:0], 1'b0};
            p_r <= p_r - 6'd1;
          end else begin
            y_r    <= x_r[63:32];
            cnt_r  <= '0;
            frac_r <= '0;
            st_r   <= L_SQ;
          end
        end
        L_SQ: begin
          y_r    <= t[32] ? t[32:1] : t[31:0];
          frac_r <= {frac_r[17:0], t[32]};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd19) begin
            res_r  <= {p_r, frac_r, t[32]};
            done_r <= 1'b1;
            st_r   <= L_IDLE;
          end
        end
        default: st_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== rtl/sff_div.sv =====
// ----------------------------------------------------------------------------
// sff_div: restoring divider
// 64-bit unsigned quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module sff_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] q_r;
  logic [63:0] rem_r;
  logic [63:0] d_r;
  logic [64:0] trial;
  logic        take;

  assign trial = {rem_r, q_r[63]};
  assign take  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= take ? 64'(trial - {1'b0, d_r}) : trial[63:0];
        q_r   <= {q_r[62:0], take};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/sff_datapath.sv =====
// ----------------------------------------------------------------------------
// sff_datapath: accumulators, log store and result formatting
// Holds the per-bin log store, the frame sums, the pitch-class ROM, the
// log2 unit, the divider and the output word register.
// ----------------------------------------------------------------------------
module sff_datapath #(
  parameter int FRAME_SIZE  = 1024,
  parameter int SAMPLE_RATE = 44100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sff_pkg::sff_cmd_t   cmd,
  output sff_pkg::sff_stat_t  stat,
  input  logic [23:0]         in_magnitude,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [9:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_feature_kind,
  output logic signed [31:0]  out_feature_value,
  output logic                out_last_of_frame
);

  localparam int NBINS = FRAME_SIZE / 2 + 1;
  localparam int BIN_W = $clog2(NBINS);

  function automatic logic [4*NBINS-1:0] class_rom_f();
    logic [4*NBINS-1:0] rom;
    logic [63:0] f;
    logic [63:0] ref_l;
    logic [63:0] v;
    logic [63:0] semis;
    rom   = '0;
    ref_l = 64'(sff_pkg::log2_q20_f(64'(440 * FRAME_SIZE)));
    for (int b = 0; b < NBINS; b++) begin
      f = 64'(b) * 64'(SAMPLE_RATE);
      rom[4*b +: 4] = sff_pkg::NO_CLASS;
      if (b != 0 && f >= 64'(55 * FRAME_SIZE) && f <= 64'(2093 * FRAME_SIZE)) begin
        v = 64'd12 * (64'(sff_pkg::log2_q20_f(f)) + (64'd4 << 20) - ref_l);
        semis = (v + (64'd1 << 19)) >> 20;
        rom[4*b +: 4] = 4'((semis + 64'd9) % 64'd12);
      end
    end
    return rom;
  endfunction

  localparam logic [4*NBINS-1:0] CLASS_ROM = class_rom_f();
  localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(NBINS - 1);

  logic [23:0] prev_mem [NBINS];

  logic [9:0]        low_last_r, voc_first_r, voc_last_r;
  logic [BIN_W-1:0]  bin_r;
  logic [23:0]       mag_r;
  logic [23:0]       prev_q_r;
  logic [3:0]        class_q_r;
  logic [47:0]       pw_r;
  logic [55:0]       lgp_r;
  logic [23:0]       lg_r;
  logic [39:0]       flux_r, low_flux_r;
  logic [63:0]       tot_r, voc_r;
  logic [39:0]       chroma_r [12];
  logic              seen_r;
  logic [63:0]       tot_s_r, voc_s_r;
  logic              dbneg_r;
  logic [55:0]       dbp_r;
  logic [31:0]       db_r;
  logic [31:0]       vr_r;
  logic              ov_r;
  logic [3:0]        kind_r;
  logic [3:0]        okind_r;
  logic [31:0]       oval_r;
  logic              olast_r;

  logic              log_done;
  logic [25:0]       log_res;
  logic              div_done;
  logic [63:0]       quot;
  logic [63:0]       log_x;
  logic [63:0]       div_a, div_b;
  logic [15:0]       bin16;
  logic [23:0]       diff_lg;
  logic signed [26:0] diff_db;
  logic [25:0]       abs_db;
  logic [23:0]       db_q;
  logic [31:0]       word;
  logic [3:0]        cidx;
  logic              out_free;

  assign bin16   = 16'(bin_r);
  assign log_x   = cmd.log_mean ? quot : 64'({1'b0, mag_r} + 25'd4096);
  assign div_a   = cmd.div_voc ? {voc_s_r[47:0], 16'd0} : tot_r;
  assign div_b   = cmd.div_voc ? tot_s_r : 64'(NBINS);
  assign diff_lg = lg_r - prev_q_r;
  assign diff_db = $signed({1'b0, log_res}) - 27'sd25165824;
  assign abs_db  = diff_db[26] ? 26'(-diff_db) : diff_db[25:0];
  assign db_q    = 24'((dbp_r + 56'd2147483648) >> 32);
  assign out_free = !ov_r || out_ready;

  sff_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  sff_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) prev_q_r <= prev_mem[bin_r];
    if (cmd.upd) prev_mem[bin_r] <= lg_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r     <= in_magnitude;
      class_q_r <= CLASS_ROM[{bin_r, 2'b00} +: 4];
      pw_r      <= {24'd0, in_magnitude} * {24'd0, in_magnitude};
    end
    if (cmd.lg_mul) lgp_r <= 56'(log_res - 26'(12 << 20)) * 56'(sff_pkg::LN2_Q32);
    if (cmd.lg_fin) lg_r <= 24'((lgp_r + 56'd2147483648) >> 32);
    if (cmd.div_start && !cmd.div_voc) begin
      tot_s_r <= tot_r;
      voc_s_r <= voc_r;
    end else if (cmd.shift) begin
      tot_s_r <= {1'b0, tot_s_r[63:1]};
      voc_s_r <= {1'b0, voc_s_r[63:1]};
    end
    if (cmd.db_mul) begin
      dbneg_r <= diff_db[26];
      dbp_r   <= 56'(abs_db) * 56'(sff_pkg::DB_OCT_Q28);
    end
    if (cmd.mean_zero) db_r <= sff_pkg::FLOOR_DB;
    else if (cmd.db_fin) db_r <= dbneg_r ? 32'(-{8'd0, db_q}) : {8'd0, db_q};
    if (cmd.vr_fin) vr_r <= sff_pkg::sat_q16(quot);
    else if (cmd.vr_clr) vr_r <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_last_r  <= 10'd4;
      voc_first_r <= 10'd4;
      voc_last_r  <= 10'd92;
      bin_r       <= '0;
      flux_r      <= '0;
      low_flux_r  <= '0;
      tot_r       <= '0;
      voc_r       <= '0;
      seen_r      <= 1'b0;
      kind_r      <= '0;
      for (int k = 0; k < 12; k++) chroma_r[k] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sff_pkg::REG_LOW_LAST:  low_last_r  <= cfg_data;
          sff_pkg::REG_VOC_FIRST: voc_first_r <= cfg_data;
          sff_pkg::REG_VOC_LAST:  voc_last_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.upd) begin
        // first frame's flux is discarded, so stale log entries are never summed
        if (seen_r && lg_r > prev_q_r) begin
          flux_r <= flux_r + 40'(diff_lg);
          if (bin16 <= 16'(low_last_r)) low_flux_r <= low_flux_r + 40'(diff_lg);
        end
        tot_r <= tot_r + 64'(pw_r);
        if (bin16 >= 16'(voc_first_r) && bin16 <= 16'(voc_last_r))
          voc_r <= voc_r + 64'(pw_r);
        for (int k = 0; k < 12; k++)
          if (class_q_r == 4'(k)) chroma_r[k] <= chroma_r[k] + 40'(mag_r);
        if (bin_r == LAST_BIN) begin
          bin_r  <= '0;
          seen_r <= 1'b1;
        end else begin
          bin_r <= bin_r + 1'b1;
        end
      end
      if (cmd.emit && out_free) kind_r <= kind_r + 4'd1;
      if (cmd.clear) begin
        flux_r     <= '0;
        low_flux_r <= '0;
        tot_r      <= '0;
        voc_r      <= '0;
        kind_r     <= '0;
        for (int k = 0; k < 12; k++) chroma_r[k] <= '0;
      end
    end
  end

  assign cidx = kind_r - 4'd4;

  always_comb begin
    case (kind_r)
      sff_pkg::KIND_FLUX:  word = sff_pkg::sat_q16(64'(flux_r >> 4));
      sff_pkg::KIND_LOW:   word = sff_pkg::sat_q16(64'(low_flux_r >> 4));
      sff_pkg::KIND_RMS:   word = db_r;
      sff_pkg::KIND_VOCAL: word = vr_r;
      default:             word = (cidx < 4'd12) ?
                                  sff_pkg::sat_q16({20'd0, chroma_r[cidx], 4'd0}) : '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit && out_free) begin
      ov_r    <= 1'b1;
      okind_r <= kind_r;
      oval_r  <= word;
      olast_r <= kind_r == sff_pkg::KIND_LAST;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  assign stat.log_done  = log_done;
  assign stat.div_done  = div_done;
  assign stat.last_bin  = bin_r == LAST_BIN;
  assign stat.mean_zero = quot == 64'd0;
  assign stat.tot_big   = tot_s_r[63:47] != 17'd0;
  assign stat.tot_zero  = tot_s_r == 64'd0;
  assign stat.out_free  = out_free;
  assign stat.kind_last = kind_r == sff_pkg::KIND_LAST;

  assign out_valid         = ov_r;
  assign out_feature_kind  = okind_r;
  assign out_feature_value = $signed(oval_r);
  assign out_last_of_frame = olast_r;

endmodule

// ===== rtl/sff_ctrl.sv =====
// ----------------------------------------------------------------------------
// sff_ctrl: sequencing state machine
// Steps each bin through log and accumulate, and at frame end through the
// mean, dB, vocal ratio and the sixteen output words.
// ----------------------------------------------------------------------------
module sff_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sff_pkg::sff_stat_t stat,
  output sff_pkg::sff_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOGB  = 5'd1;
  localparam logic [4:0] S_LOGBW = 5'd2;
  localparam logic [4:0] S_LMUL  = 5'd3;
  localparam logic [4:0] S_LRND  = 5'd4;
  localparam logic [4:0] S_UPD   = 5'd5;
  localparam logic [4:0] S_DIV1  = 5'd6;
  localparam logic [4:0] S_DIV1W = 5'd7;
  localparam logic [4:0] S_LOGM  = 5'd8;
  localparam logic [4:0] S_LOGMW = 5'd9;
  localparam logic [4:0] S_DBM   = 5'd10;
  localparam logic [4:0] S_DBR   = 5'd11;
  localparam logic [4:0] S_SHF   = 5'd12;
  localparam logic [4:0] S_DIV2  = 5'd13;
  localparam logic [4:0] S_DIV2W = 5'd14;
  localparam logic [4:0] S_EMIT  = 5'd15;
  localparam logic [4:0] S_CLR   = 5'd16;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOGB;
        end
      end
      S_LOGB: begin
        cmd.log_start = 1'b1;
        state_nxt     = S_LOGBW;
      end
      S_LOGBW: if (stat.log_done) state_nxt = S_LMUL;
      S_LMUL: begin
        cmd.lg_mul = 1'b1;
        state_nxt  = S_LRND;
      end
      S_LRND: begin
        cmd.lg_fin = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = stat.last_bin ? S_DIV1 : S_IDLE;
      end
      S_DIV1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV1W;
      end
      S_DIV1W: if (stat.div_done) state_nxt = S_LOGM;
      S_LOGM: begin
        if (stat.mean_zero) begin
          cmd.mean_zero = 1'b1;
          state_nxt     = S_SHF;
        end else begin
          cmd.log_start = 1'b1;
          cmd.log_mean  = 1'b1;
          state_nxt     = S_LOGMW;
        end
      end
      S_LOGMW: if (stat.log_done) state_nxt = S_DBM;
      S_DBM: begin
        cmd.db_mul = 1'b1;
        state_nxt  = S_DBR;
      end
      S_DBR: begin
        cmd.db_fin = 1'b1;
        state_nxt  = S_SHF;
      end
      S_SHF: begin
        if (stat.tot_zero) begin
          cmd.vr_clr = 1'b1;
          state_nxt  = S_EMIT;
        end else if (stat.tot_big) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_voc   = 1'b1;
        state_nxt     = S_DIV2W;
      end
      S_DIV2W: begin
        if (stat.div_done) begin
          cmd.vr_fin = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.out_free && stat.kind_last) state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/spectral_flux_frame_features.sv =====
// ----------------------------------------------------------------------------
// spectral_flux_frame_features: per-frame spectral flux, level and chroma
// Takes FRAME_SIZE/2+1 magnitude bins per frame and emits sixteen feature
// words after the last bin.
// ----------------------------------------------------------------------------
// Bins are taken one at a time, each paced by the iterative log2 unit
// (normalise a byte or a bit a cycle, then one squaring per fraction bit).
// After the last bin of a frame come one or two divisions, one more log2
// unless the mean is zero, up to 17 scaling steps and the sixteen output
// words, one per cycle while the output side takes them; the first bin of
// the next frame is accepted once the last word is loaded and the frame
// sums are cleared. No clearing pass runs after reset: the log store is
// fully written during the first frame, whose flux is reported as zero.
module spectral_flux_frame_features #(
  parameter int FRAME_SIZE  = 1024,
  parameter int SAMPLE_RATE = 44100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_magnitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_feature_kind,
  output logic signed [31:0] out_feature_value,
  output logic               out_last_of_frame,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  sff_pkg::sff_cmd_t  cmd;
  sff_pkg::sff_stat_t stat;

  assign cfg_ready = 1'b1;

  sff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sff_datapath #(
    .FRAME_SIZE  (FRAME_SIZE),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_magnitude      (in_magnitude),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_feature_kind  (out_feature_kind),
    .out_feature_value (out_feature_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
